/* rtl/core/kccd_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
package kccd_pkg;

	localparam int LETTERS = 26;
	localparam int LW      = 5;
	localparam int KEY_W   = 60;
	localparam int LEN_W   = 4;
	localparam int BYTE_W  = 8;

	localparam logic [BYTE_W-1:0] CH_A     = 8'h41;
	localparam logic [BYTE_W-1:0] CH_Z     = 8'h5A;
	localparam logic [BYTE_W-1:0] CH_SPACE = 8'h20;

	localparam logic REG_KEY_LETTERS = 1'b0;
	localparam logic REG_KEY_LENGTH  = 1'b1;

	typedef struct packed {
		logic init;
		logic dedup;
		logic fill;
		logic cols;
		logic ident;
		logic clr_cnt;
		logic accept;
	} kccd_cmd_t;

	typedef struct packed {
		logic dedup_done;
		logic key_empty;
		logic fill_done;
		logic cols_done;
		logic ident_done;
	} kccd_sts_t;

endpackage
`default_nettype wire

/* rtl/core/kccd_ctrl.sv */
`timescale 1ns / 1ps
`default_nettype none
module kccd_ctrl (
	input  wire               clk,
	input  wire               arst_n,
	input  wire               start,
	input  wire               cfg_wr,
	input  kccd_pkg::kccd_sts_t sts,
	output kccd_pkg::kccd_cmd_t cmd,
	output logic              busy
);
	import kccd_pkg::*;

	localparam logic [2:0] S_IDLE  = 3'd0;
	localparam logic [2:0] S_INIT  = 3'd1;
	localparam logic [2:0] S_DEDUP = 3'd2;
	localparam logic [2:0] S_FILL  = 3'd3;
	localparam logic [2:0] S_COLS  = 3'd4;
	localparam logic [2:0] S_IDENT = 3'd5;

	logic [2:0] state_q;
	logic       ready_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			ready_q <= 1'b0;
		end else if (cfg_wr) begin
			state_q <= S_IDLE;
			ready_q <= 1'b0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (!ready_q) state_q <= S_INIT;
				end
				S_INIT: state_q <= S_DEDUP;
				S_DEDUP: begin
					if (sts.dedup_done) state_q <= sts.key_empty ? S_IDENT : S_FILL;
				end
				S_FILL: begin
					if (sts.fill_done) state_q <= S_COLS;
				end
				S_COLS: begin
					if (sts.cols_done) begin
						state_q <= S_IDLE;
						ready_q <= 1'b1;
					end
				end
				S_IDENT: begin
					if (sts.ident_done) begin
						state_q <= S_IDLE;
						ready_q <= 1'b1;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign busy = (state_q != S_IDLE) || !ready_q;

	always_comb begin
		cmd         = '0;
		cmd.init    = (state_q == S_INIT);
		cmd.dedup   = (state_q == S_DEDUP);
		cmd.fill    = (state_q == S_FILL);
		cmd.cols    = (state_q == S_COLS);
		cmd.ident   = (state_q == S_IDENT);
		cmd.clr_cnt = ((state_q == S_DEDUP) && sts.dedup_done) ||
		              ((state_q == S_FILL) && sts.fill_done);
		cmd.accept  = start && !busy;
	end

`ifndef SYNTH
	a_cfg_busy: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_wr |=> busy)
		else $error("table not invalidated by register write");
	a_dedup_next: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DEDUP && sts.dedup_done && !cfg_wr) |=>
		(state_q == S_FILL || state_q == S_IDENT))
		else $error("dedup phase did not advance");
	a_ready_src: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(ready_q) |-> $past(state_q == S_COLS || state_q == S_IDENT))
		else $error("table ready without a build");
`endif
endmodule
`default_nettype wire

/* rtl/core/kccd_datapath.sv */
`timescale 1ns / 1ps
`default_nettype none
module kccd_datapath #(
	parameter int MAX_KEY = 12
) (
	input  wire                          clk,
	input  wire                          arst_n,
	input  kccd_pkg::kccd_cmd_t          cmd,
	output kccd_pkg::kccd_sts_t          sts,
	input  wire [kccd_pkg::KEY_W-1:0]    keyword_letters,
	input  wire [kccd_pkg::LEN_W-1:0]    keyword_length,
	input  wire [kccd_pkg::BYTE_W-1:0]   cipher_byte,
	output logic                         done,
	output logic [kccd_pkg::BYTE_W-1:0]  plain_byte,
	output logic                         bad_byte
);
	import kccd_pkg::*;

	localparam int WW = $clog2(MAX_KEY + 1);

	logic [LW-1:0]      cnt_q;
	logic [LW-1:0]      n_q;
	logic [LW-1:0]      q_q;
	logic [LW-1:0]      pos_q;
	logic [WW-1:0]      width_q;
	logic               in_col_q;
	logic [LETTERS-1:0] used_q;
	logic [LW-1:0]      seq_q [LETTERS];
	logic [LW-1:0]      tbl_mem [LETTERS];

	logic [LEN_W-1:0]   len_sat;
	logic [LW-1:0]      cur_letter;
	logic               cur_new;
	logic [LW-1:0]      col;
	logic [LW:0]        q_next;
	logic               tbl_we;
	logic [LW-1:0]      tbl_waddr;
	logic [LW-1:0]      tbl_wdata;

	logic               valid_s1;
	logic [BYTE_W-1:0]  byte_s1;
	logic [LW-1:0]      rd_s1;
	logic               in_letter;
	logic [BYTE_W-1:0]  in_off;
	logic               s1_letter;
	logic               s1_space;

	assign len_sat = (keyword_length > LEN_W'(MAX_KEY)) ? LEN_W'(MAX_KEY) : keyword_length;

	always_comb begin
		cur_letter = '0;
		for (int i = 0; i < MAX_KEY; i++) begin
			if (cnt_q == LW'(i)) cur_letter = keyword_letters[LW*i +: LW];
		end
	end

	assign cur_new = (cur_letter < LW'(LETTERS)) && !used_q[cur_letter];

	// column of the current keyword letter
	always_comb begin
		col = '0;
		for (int j = 0; j < MAX_KEY; j++) begin
			if ((WW'(j) < width_q) && (seq_q[j] == cnt_q)) col = col | LW'(j);
		end
	end

	assign q_next = {1'b0, q_q} + (LW+1)'(width_q);

	assign sts.dedup_done = (cnt_q == {1'b0, len_sat});
	assign sts.key_empty  = (width_q == '0);
	assign sts.fill_done  = (cnt_q == LW'(LETTERS));
	assign sts.cols_done  = (cnt_q == LW'(LETTERS));
	assign sts.ident_done = (cnt_q == LW'(LETTERS));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q    <= '0;
			n_q      <= '0;
			q_q      <= '0;
			pos_q    <= '0;
			width_q  <= '0;
			in_col_q <= 1'b0;
			used_q   <= '0;
		end else if (cmd.init) begin
			cnt_q    <= '0;
			n_q      <= '0;
			pos_q    <= '0;
			width_q  <= '0;
			in_col_q <= 1'b0;
			used_q   <= '0;
		end else if (cmd.clr_cnt) begin
			cnt_q <= '0;
		end else if (cmd.dedup && !sts.dedup_done) begin
			cnt_q <= cnt_q + 1'b1;
			if (cur_new) begin
				used_q[cur_letter] <= 1'b1;
				n_q                <= n_q + 1'b1;
				width_q            <= width_q + 1'b1;
			end
		end else if (cmd.fill && !sts.fill_done) begin
			cnt_q <= cnt_q + 1'b1;
			if (!used_q[cnt_q]) n_q <= n_q + 1'b1;
		end else if (cmd.cols && !sts.cols_done) begin
			if (!in_col_q) begin
				if (used_q[cnt_q]) begin
					q_q      <= col;
					in_col_q <= 1'b1;
				end else begin
					cnt_q <= cnt_q + 1'b1;
				end
			end else begin
				pos_q <= pos_q + 1'b1;
				if (q_next >= (LW+1)'(LETTERS)) begin
					in_col_q <= 1'b0;
					cnt_q    <= cnt_q + 1'b1;
				end else begin
					q_q <= q_next[LW-1:0];
				end
			end
		end else if (cmd.ident && !sts.ident_done) begin
			cnt_q <= cnt_q + 1'b1;
		end
	end

	// column sequence: kept keyword letters then the unused letters
	always_ff @(posedge clk) begin
		if (cmd.dedup && !sts.dedup_done && cur_new) seq_q[n_q] <= cur_letter;
		else if (cmd.fill && !sts.fill_done && !used_q[cnt_q]) seq_q[n_q] <= cnt_q;
	end

	always_comb begin
		tbl_we    = 1'b0;
		tbl_waddr = cnt_q;
		tbl_wdata = cnt_q;
		if (cmd.cols && !sts.cols_done && in_col_q) begin
			tbl_we    = 1'b1;
			tbl_waddr = seq_q[q_q];
			tbl_wdata = pos_q;
		end else if (cmd.ident && !sts.ident_done) begin
			tbl_we = 1'b1;
		end
	end

	assign in_off    = cipher_byte - CH_A;
	assign in_letter = (cipher_byte >= CH_A) && (cipher_byte <= CH_Z);

	always_ff @(posedge clk) begin
		if (tbl_we) tbl_mem[tbl_waddr] <= tbl_wdata;
		if (cmd.accept && in_letter) rd_s1 <= tbl_mem[in_off[LW-1:0]];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) valid_s1 <= 1'b0;
		else         valid_s1 <= cmd.accept;
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) byte_s1 <= cipher_byte;
	end

	assign s1_letter = (byte_s1 >= CH_A) && (byte_s1 <= CH_Z);
	assign s1_space  = (byte_s1 == CH_SPACE);

	always_comb begin
		done       = valid_s1;
		bad_byte   = !(s1_letter || s1_space);
		plain_byte = '0;
		if (s1_letter)     plain_byte = CH_A + BYTE_W'(rd_s1);
		else if (s1_space) plain_byte = CH_SPACE;
	end
endmodule
`default_nettype wire

/* rtl/core/keyword_columnar_cipher_decoder_unit.sv */
`timescale 1ns / 1ps
`default_nettype none
// keyword columnar cipher decoder
// config: apb-style port, 64-bit data; keyword_letters at 0x0, keyword_length at 0x8.
//   any write invalidates the decode table and restarts its build.
// input: a beat is taken when start is high and busy is low; cipher_byte carries it.
// output: done is high for one cycle with plain_byte and bad_byte, in the cycle after
//   the input beat; the receiver cannot stall, so results are never held back.
// throughput: one byte per cycle once the table is built, set by a single read
//   of the 26-entry decode table per byte.
// table build: after reset and after each register write busy stays high through
//   idle and init, a dedup sweep over keyword_length capped at MAX_KEY letters,
//   a letter fill sweep and a column walk that writes each table entry; an empty
//   keyword skips fill and walk and writes an identity table instead.
// reset: clears registers to keyword_length 1, keyword_letters 0, then builds.
// bytes other than uppercase letters and space give bad_byte with plain_byte 0.
module keyword_columnar_cipher_decoder_unit #(
	parameter int MAX_KEY = 12
) (
	input  wire         clk,
	input  wire         arst_n,
	input  wire         psel,
	input  wire         penable,
	input  wire         pwrite,
	input  wire  [3:0]  paddr,
	input  wire  [63:0] pwdata,
	output logic [63:0] prdata,
	output logic        pready,
	input  wire         start,
	output logic        busy,
	input  wire  [7:0]  cipher_byte,
	output logic        done,
	output logic [7:0]  plain_byte,
	output logic        bad_byte
);
	import kccd_pkg::*;

	logic [KEY_W-1:0] keyword_letters_q;
	logic [LEN_W-1:0] keyword_length_q;
	logic             cfg_wr;
	kccd_cmd_t        cmd;
	kccd_sts_t        sts;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			keyword_letters_q <= '0;
			keyword_length_q  <= LEN_W'(1);
		end else if (cfg_wr) begin
			unique case (paddr[3])
				REG_KEY_LETTERS: keyword_letters_q <= pwdata[KEY_W-1:0];
				REG_KEY_LENGTH:  keyword_length_q  <= pwdata[LEN_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[3])
			REG_KEY_LETTERS: prdata = {{(64-KEY_W){1'b0}}, keyword_letters_q};
			REG_KEY_LENGTH:  prdata = {{(64-LEN_W){1'b0}}, keyword_length_q};
			default:         prdata = '0;
		endcase
	end

	kccd_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.cfg_wr (cfg_wr),
		.sts    (sts),
		.cmd    (cmd),
		.busy   (busy)
	);

	kccd_datapath #(
		.MAX_KEY (MAX_KEY)
	) u_datapath (
		.clk             (clk),
		.arst_n          (arst_n),
		.cmd             (cmd),
		.sts             (sts),
		.keyword_letters (keyword_letters_q),
		.keyword_length  (keyword_length_q),
		.cipher_byte     (cipher_byte),
		.done            (done),
		.plain_byte      (plain_byte),
		.bad_byte        (bad_byte)
	);

`ifndef SYNTH
	a_done_src: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start && !busy))
		else $error("result beat without an input beat");
`endif
endmodule
`default_nettype wire

/* tb/keyword_columnar_cipher_decoder_unit_tb.sv */
`timescale 1ns / 1ps
module keyword_columnar_cipher_decoder_unit_tb;
	import kccd_pkg::*;

	localparam int KEY_MAX     = 12;
	localparam int CYCLE_LIMIT = 200000;

	typedef struct {
		logic [BYTE_W-1:0] cipher;
		logic [BYTE_W-1:0] plain;
		logic              bad;
	} plain_beat_t;

	class plaintext_tracker;
		logic [KEY_W-1:0] key_letters;
		logic [LEN_W-1:0] key_len;
		logic [LW-1:0]    plain_pos [LETTERS];
		plain_beat_t      plain_due [$];
		int               mismatches;

		function new();
			key_letters = '0;
			key_len     = LEN_W'(1);
			mismatches  = 0;
			rebuild();
		endfunction

		function void flag(string msg);
			mismatches++;
			if (mismatches <= 10)
				$display("[%0t] mismatch: %s", $realtime, msg);
		endfunction

		function void write_reg(logic idx, logic [63:0] value);
			if (idx == REG_KEY_LETTERS)
				key_letters = value[KEY_W-1:0];
			else
				key_len = value[LEN_W-1:0];
			rebuild();
		endfunction

		// grid columns in keyword-letter order, read top to bottom
		function void rebuild();
			bit         used [LETTERS];
			logic [4:0] seq [LETTERS];
			int         len;
			int         width;
			int         n;
			int         pos;
			logic [4:0] c;
			for (int i = 0; i < LETTERS; i++)
				used[i] = 0;
			len = int'(key_len);
			if (len > KEY_MAX)
				len = KEY_MAX;
			width = 0;
			for (int i = 0; i < len; i++) begin
				c = key_letters[5*i +: 5];
				if (c < LETTERS && !used[c]) begin
					used[c] = 1;
					seq[width] = c;
					width++;
				end
			end
			if (width == 0) begin
				for (int i = 0; i < LETTERS; i++)
					plain_pos[i] = LW'(i);
				return;
			end
			n = width;
			for (int i = 0; i < LETTERS; i++) begin
				if (!used[i]) begin
					seq[n] = 5'(i);
					n++;
				end
			end
			pos = 0;
			for (int letter = 0; letter < LETTERS; letter++) begin
				if (!used[letter])
					continue;
				for (int col = 0; col < width; col++) begin
					if (seq[col] == letter) begin
						for (int q = col; q < LETTERS; q += width) begin
							plain_pos[seq[q]] = LW'(pos);
							pos++;
						end
						break;
					end
				end
			end
		endfunction

		function void note_cipher(logic [BYTE_W-1:0] b);
			plain_beat_t e;
			e.cipher = b;
			if (b >= CH_A && b <= CH_Z) begin
				e.plain = CH_A + {3'b000, plain_pos[LW'(b - CH_A)]};
				e.bad   = 1'b0;
			end else if (b == CH_SPACE) begin
				e.plain = CH_SPACE;
				e.bad   = 1'b0;
			end else begin
				e.plain = '0;
				e.bad   = 1'b1;
			end
			plain_due.push_back(e);
		endfunction

		function void check_plain(logic [BYTE_W-1:0] p, logic bad);
			plain_beat_t e;
			if (plain_due.size() == 0) begin
				flag($sformatf("unexpected beat plain=%02h bad=%b", p, bad));
				return;
			end
			e = plain_due.pop_front();
			if (p !== e.plain || bad !== e.bad)
				flag($sformatf("cipher %02h: expected plain=%02h bad=%b, got plain=%02h bad=%b",
					e.cipher, e.plain, e.bad, p, bad));
		endfunction
	endclass

	logic        clk         = 1'b0;
	logic        arst_n      = 1'b0;
	logic        psel        = 1'b0;
	logic        penable     = 1'b0;
	logic        pwrite      = 1'b0;
	logic [3:0]  paddr       = '0;
	logic [63:0] pwdata      = '0;
	logic [63:0] prdata;
	logic        pready;
	logic        start       = 1'b0;
	logic        busy;
	logic [7:0]  cipher_byte = '0;
	logic        done;
	logic [7:0]  plain_byte;
	logic        bad_byte;

	plaintext_tracker board;
	bit               idle_on = 1;
	int               cycles  = 0;

	keyword_columnar_cipher_decoder_unit i_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.psel        (psel),
		.penable     (penable),
		.pwrite      (pwrite),
		.paddr       (paddr),
		.pwdata      (pwdata),
		.prdata      (prdata),
		.pready      (pready),
		.start       (start),
		.busy        (busy),
		.cipher_byte (cipher_byte),
		.done        (done),
		.plain_byte  (plain_byte),
		.bad_byte    (bad_byte)
	);

	always #5 clk = ~clk;

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("Test completed with failures");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (done)
				board.check_plain(plain_byte, bad_byte);
			if (start && !busy)
				board.note_cipher(cipher_byte);
		end
	end

	function automatic logic [7:0] random_cipher();
		int r;
		r = $urandom_range(99);
		if (r < 60)
			return CH_A + 8'($urandom_range(25));
		else if (r < 75)
			return CH_SPACE;
		return 8'($urandom_range(255));
	endfunction

	function automatic logic [KEY_W-1:0] random_key(int bad_pct);
		logic [KEY_W-1:0] k;
		for (int i = 0; i < KEY_MAX; i++) begin
			if ($urandom_range(99) < bad_pct)
				k[5*i +: 5] = 5'($urandom_range(31, 26));
			else
				k[5*i +: 5] = 5'($urandom_range(25));
		end
		return k;
	endfunction

	task automatic send_byte(logic [7:0] b);
		while (idle_on && $urandom_range(99) < 23) begin
			start       = 1'b0;
			cipher_byte = 8'($urandom);
			@(negedge clk);
		end
		start       = 1'b1;
		cipher_byte = b;
		do
			@(posedge clk);
		while (busy);
		@(negedge clk);
	endtask

	task automatic drain();
		start = 1'b0;
		while (board.plain_due.size() != 0)
			@(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	task automatic apb_write(logic idx, logic [63:0] value);
		psel    = 1'b1;
		penable = 1'b0;
		pwrite  = 1'b1;
		paddr   = {idx, 3'b000};
		pwdata  = value;
		@(negedge clk);
		penable = 1'b1;
		do
			@(posedge clk);
		while (!pready);
		board.write_reg(idx, value);
		@(negedge clk);
		psel    = 1'b0;
		penable = 1'b0;
		pwrite  = 1'b0;
		@(negedge clk);
	endtask

	task automatic set_keyword(logic [KEY_W-1:0] k, logic [LEN_W-1:0] len);
		drain();
		if ($urandom_range(1)) begin
			apb_write(REG_KEY_LETTERS, {4'h0, k});
			apb_write(REG_KEY_LENGTH, {60'd0, len});
		end else begin
			apb_write(REG_KEY_LENGTH, {60'd0, len});
			apb_write(REG_KEY_LETTERS, {4'h0, k});
		end
	endtask

	task automatic run_random(int count);
		for (int i = 0; i < count; i++)
			send_byte(random_cipher());
	endtask

	initial begin
		logic [7:0]       edge_bytes [16];
		logic [KEY_W-1:0] k;
		board = new();
		edge_bytes = '{8'h41, 8'h5A, 8'h20, 8'h00, 8'hFF, 8'h40, 8'h5B, 8'h1F,
			8'h21, 8'h61, 8'h7A, 8'h7F, 8'h80, 8'h4D, 8'h4E, 8'hBE};
		repeat (8) @(negedge clk);
		arst_n = 1'b1;

		foreach (edge_bytes[i])
			send_byte(edge_bytes[i]);

		// empty keyword
		set_keyword(random_key(0), 4'd0);
		run_random(40);
		// every code out of range, length saturating
		set_keyword({KEY_W{1'b1}}, 4'd15);
		run_random(40);
		// one letter repeated twelve times
		set_keyword('0, 4'd12);
		run_random(40);
		for (int i = 0; i < KEY_MAX; i++)
			k[5*i +: 5] = 5'(25 - i);
		set_keyword(k, 4'd15);
		run_random(40);
		set_keyword(random_key(50), 4'd12);
		run_random(40);

		for (int ph = 0; ph < 12; ph++) begin
			idle_on = (ph != 3);
			set_keyword(random_key($urandom_range(1) ? 0 : 15), 4'($urandom_range(15)));
			if (ph == 6) begin
				run_random(55);
				drain();
				run_random(55);
			end else begin
				run_random(110);
			end
		end
		idle_on = 1;

		drain();
		repeat (10) @(negedge clk);
		if (board.plain_due.size() != 0)
			board.flag($sformatf("%0d bytes never decoded", board.plain_due.size()));
		if (board.mismatches == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule

/* files.f */
rtl/core/kccd_pkg.sv
rtl/core/kccd_ctrl.sv
rtl/core/kccd_datapath.sv
rtl/core/keyword_columnar_cipher_decoder_unit.sv
tb/keyword_columnar_cipher_decoder_unit_tb.sv
